// ===== rtl/attempt_statistics_mean_stddev_minmax_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef ATTEMPT_STATISTICS_MEAN_STDDEV_MINMAX_DEFINES_SVH
`define ATTEMPT_STATISTICS_MEAN_STDDEV_MINMAX_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequence violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/attstat_pkg.sv =====
`timescale 1ns / 1ps

package attstat_pkg;

    localparam int MAX_SESSIONS = 1024;
    localparam int FRAC_BITS    = 8;

    localparam int ATT_W   = 16;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 26;
    localparam int SQ_W    = 42;
    localparam int OUT_W   = 24;

    // n * sumsq and the variance numerator
    localparam int DIFF_W  = CNT_W + SQ_W;
    localparam int SUMSQ_W = 2 * SUM_W;
    // divider: widest dividend is the variance numerator with its fraction bits
    localparam int DVD_W   = DIFF_W + 2 * FRAC_BITS;
    localparam int DVS_W   = 2 * CNT_W - 1;
    localparam int REM_W   = DVS_W + 1;
    localparam int STEP_W  = $clog2(DVD_W);
    // square root of the scaled variance
    localparam int ROOT_W  = OUT_W;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int SQR_W   = ROOT_W + 3;

endpackage

// ===== rtl/attempt_statistics_mean_stddev_minmax.sv =====
`timescale 1ns / 1ps
`include "attempt_statistics_mean_stddev_minmax_defines.svh"

// Channel   Handshake               Payload
// in        in_valid / in_ready     attempts, low_guesses, high_guesses, last
// out       out_valid / out_ready   session_total, mean_q8, deviation_q8, fewest,
//                                   most, low_avg_q8, high_avg_q8, overflow
//
// A session that is not last is accumulated as it is accepted; items may follow back to back.
// The last item starts the finish sequence: the multiply and difference states, four passes
// of the shared restoring divider (a load, then the bit steps), the square-root steps and
// a load of the result into the output register.
// in_ready is low during that sequence; a result waiting on out_ready stalls only the
// next finish, not accumulation. Asynchronous active-low reset clears every counter.

module attempt_statistics_mean_stddev_minmax (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [attstat_pkg::ATT_W-1:0]   attempts,
    input  logic [attstat_pkg::ATT_W-1:0]   low_guesses,
    input  logic [attstat_pkg::ATT_W-1:0]   high_guesses,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [attstat_pkg::CNT_W-1:0]   session_total,
    output logic [attstat_pkg::OUT_W-1:0]   mean_q8,
    output logic [attstat_pkg::OUT_W-1:0]   deviation_q8,
    output logic [attstat_pkg::ATT_W-1:0]   fewest,
    output logic [attstat_pkg::ATT_W-1:0]   most,
    output logic [attstat_pkg::OUT_W-1:0]   low_avg_q8,
    output logic [attstat_pkg::OUT_W-1:0]   high_avg_q8,
    output logic                            overflow
);
    import attstat_pkg::*;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_DIFF,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_MEAN,
        OP_LOW,
        OP_HIGH,
        OP_VAR
    } op_t;

    state_t                 state_reg;
    op_t                    op_reg;

    logic [CNT_W-1:0]       count_seen_reg;
    logic [SUM_W-1:0]       attempt_sum_reg;
    logic [SQ_W-1:0]        square_sum_reg;
    logic [ATT_W-1:0]       min_seen_reg;
    logic [ATT_W-1:0]       max_seen_reg;
    logic [SUM_W-1:0]       low_sum_reg;
    logic [SUM_W-1:0]       high_sum_reg;
    logic                   dropped_reg;

    logic [DIFF_W-1:0]      prod_reg;
    logic [DVS_W-1:0]       n2_reg;
    logic [DIFF_W-1:0]      diff_reg;

    logic [DVD_W-1:0]       dvd_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [DVS_W-1:0]       dvs_reg;
    logic [STEP_W-1:0]      step_reg;

    logic [OUT_W-1:0]       mean_reg;
    logic [OUT_W-1:0]       low_avg_reg;
    logic [OUT_W-1:0]       high_avg_reg;

    logic [RAD_W-1:0]       rad_reg;
    logic [SQR_W-1:0]       sq_rem_reg;
    logic [ROOT_W-1:0]      root_reg;

    logic                   out_valid_reg;
    logic [CNT_W-1:0]       session_total_reg;
    logic [OUT_W-1:0]       mean_out_reg;
    logic [OUT_W-1:0]       deviation_reg;
    logic [ATT_W-1:0]       fewest_reg;
    logic [ATT_W-1:0]       most_reg;
    logic [OUT_W-1:0]       low_out_reg;
    logic [OUT_W-1:0]       high_out_reg;
    logic                   overflow_reg;

    logic                   accept;
    logic                   has_room;
    logic                   out_free;
    logic [2*ATT_W-1:0]     sq_term;
    logic [DIFF_W-1:0]      nsq_prod;
    logic [SUMSQ_W-1:0]     sum_sq;
    logic [DVS_W-1:0]       n2_prod;

    logic [REM_W-1:0]       rem_shift;
    logic                   div_take;
    logic [REM_W-1:0]       rem_next;
    logic [DVD_W-1:0]       dvd_next;

    logic [SQR_W-1:0]       sq_shift;
    logic [SQR_W-1:0]       sq_trial;
    logic                   sq_take;
    logic [SQR_W-1:0]       sq_rem_next;
    logic [ROOT_W-1:0]      root_next;

    assign accept   = in_valid && in_ready;
    assign has_room = (count_seen_reg != CNT_W'(MAX_SESSIONS));
    assign out_free = !out_valid_reg || out_ready;

    assign sq_term  = attempts * attempts;
    assign nsq_prod = count_seen_reg * square_sum_reg;
    assign sum_sq   = attempt_sum_reg * attempt_sum_reg;
    assign n2_prod  = count_seen_reg * count_seen_reg;

    // restoring divider, one quotient bit a cycle
    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign div_take  = (rem_shift >= {1'b0, dvs_reg});
    assign rem_next  = div_take ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    assign dvd_next  = {dvd_reg[DVD_W-2:0], div_take};

    // digit-by-digit square root, one root bit a cycle
    assign sq_shift    = {sq_rem_reg[SQR_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial    = {1'b0, root_reg, 2'b01};
    assign sq_take     = (sq_shift >= sq_trial);
    assign sq_rem_next = sq_take ? (sq_shift - sq_trial) : sq_shift;
    assign root_next   = {root_reg[ROOT_W-2:0], sq_take};

    assign in_ready = (state_reg == ST_ACC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_ACC;
            op_reg            <= OP_MEAN;
            count_seen_reg    <= '0;
            attempt_sum_reg   <= '0;
            square_sum_reg    <= '0;
            min_seen_reg      <= '0;
            max_seen_reg      <= '0;
            low_sum_reg       <= '0;
            high_sum_reg      <= '0;
            dropped_reg       <= 1'b0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // the finish state owns the valid flag while it waits to load
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_ACC:
                begin
                    if (accept)
                    begin
                        if (has_room)
                        begin
                            if (count_seen_reg == '0)
                            begin
                                min_seen_reg <= attempts;
                                max_seen_reg <= attempts;
                            end
                            else
                            begin
                                if (attempts < min_seen_reg)
                                begin
                                    min_seen_reg <= attempts;
                                end
                                if (attempts > max_seen_reg)
                                begin
                                    max_seen_reg <= attempts;
                                end
                            end
                            count_seen_reg  <= count_seen_reg + 1'b1;
                            attempt_sum_reg <= attempt_sum_reg + SUM_W'(attempts);
                            square_sum_reg  <= square_sum_reg + SQ_W'(sq_term);
                            low_sum_reg     <= low_sum_reg + SUM_W'(low_guesses);
                            high_sum_reg    <= high_sum_reg + SUM_W'(high_guesses);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    prod_reg  <= nsq_prod;
                    n2_reg    <= n2_prod;
                    state_reg <= ST_DIFF;
                end

                ST_DIFF:
                begin
                    // exact: n*sumsq never falls below sum^2
                    diff_reg  <= prod_reg - DIFF_W'(sum_sq);
                    op_reg    <= OP_MEAN;
                    state_reg <= ST_DIV_LOAD;
                end

                ST_DIV_LOAD:
                begin
                    rem_reg  <= '0;
                    step_reg <= STEP_W'(DVD_W - 1);
                    case (op_reg)
                        OP_MEAN:
                        begin
                            dvd_reg <= DVD_W'(attempt_sum_reg) << FRAC_BITS;
                            dvs_reg <= DVS_W'(count_seen_reg);
                        end
                        OP_LOW:
                        begin
                            dvd_reg <= DVD_W'(low_sum_reg) << FRAC_BITS;
                            dvs_reg <= DVS_W'(count_seen_reg);
                        end
                        OP_HIGH:
                        begin
                            dvd_reg <= DVD_W'(high_sum_reg) << FRAC_BITS;
                            dvs_reg <= DVS_W'(count_seen_reg);
                        end
                        default:
                        begin
                            dvd_reg <= DVD_W'(diff_reg) << (2 * FRAC_BITS);
                            dvs_reg <= n2_reg;
                        end
                    endcase
                    state_reg <= ST_DIV_RUN;
                end

                ST_DIV_RUN:
                begin
                    rem_reg <= rem_next;
                    dvd_reg <= dvd_next;
                    if (step_reg == '0)
                    begin
                        case (op_reg)
                            OP_MEAN:
                            begin
                                mean_reg  <= dvd_next[OUT_W-1:0];
                                op_reg    <= OP_LOW;
                                state_reg <= ST_DIV_LOAD;
                            end
                            OP_LOW:
                            begin
                                low_avg_reg <= dvd_next[OUT_W-1:0];
                                op_reg      <= OP_HIGH;
                                state_reg   <= ST_DIV_LOAD;
                            end
                            OP_HIGH:
                            begin
                                high_avg_reg <= dvd_next[OUT_W-1:0];
                                op_reg       <= OP_VAR;
                                state_reg    <= ST_DIV_LOAD;
                            end
                            default:
                            begin
                                // scaled variance stays below 2^RAD_W
                                rad_reg    <= dvd_next[RAD_W-1:0];
                                sq_rem_reg <= '0;
                                root_reg   <= '0;
                                step_reg   <= STEP_W'(ROOT_W - 1);
                                state_reg  <= ST_SQRT;
                            end
                        endcase
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end

                ST_SQRT:
                begin
                    rad_reg    <= rad_reg << 2;
                    sq_rem_reg <= sq_rem_next;
                    root_reg   <= root_next;
                    step_reg   <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    // hold until the output register is free, then clear for the next history
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        session_total_reg <= count_seen_reg;
                        mean_out_reg      <= mean_reg;
                        deviation_reg     <= root_reg;
                        fewest_reg        <= min_seen_reg;
                        most_reg          <= max_seen_reg;
                        low_out_reg       <= low_avg_reg;
                        high_out_reg      <= high_avg_reg;
                        overflow_reg      <= dropped_reg;
                        count_seen_reg    <= '0;
                        attempt_sum_reg   <= '0;
                        square_sum_reg    <= '0;
                        min_seen_reg      <= '0;
                        max_seen_reg      <= '0;
                        low_sum_reg       <= '0;
                        high_sum_reg      <= '0;
                        dropped_reg       <= 1'b0;
                        state_reg         <= ST_ACC;
                    end
                end

                default:
                begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign session_total = session_total_reg;
    assign mean_q8       = mean_out_reg;
    assign deviation_q8  = deviation_reg;
    assign fewest        = fewest_reg;
    assign most          = most_reg;
    assign low_avg_q8    = low_out_reg;
    assign high_avg_q8   = high_out_reg;
    assign overflow      = overflow_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_seen_reg <= CNT_W'(MAX_SESSIONS))
    `ASSERT_ALWAYS(a_min_le_max, clk, rst_n, (count_seen_reg == '0) || (min_seen_reg <= max_seen_reg))
    `ASSERT_NEXT(a_last_starts, clk, rst_n, in_valid && in_ready && last, state_reg == ST_MUL)
    `ASSERT_NEXT(a_done_loads, clk, rst_n, (state_reg == ST_DONE) && out_free, out_valid && in_ready && (count_seen_reg == '0))

endmodule
